@@ rtl/orl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the relocating object loader.
package orl_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int MAX_MOD_BYTES = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int MODN_BITS     = $clog2(MAX_MOD_BYTES + 1);

    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_TEXT   = 3'd1;
    localparam logic [2:0] EV_MOD    = 3'd2;
    localparam logic [2:0] EV_END    = 3'd3;
    localparam logic [2:0] EV_READ   = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_HEX     = 2'd1;
    localparam logic [1:0] ERR_RANGE   = 2'd2;
    localparam logic [1:0] ERR_MODLONG = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_H,
        KIND_T,
        KIND_M,
        KIND_E
    } rec_kind_t;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_EVENT
    } cmd_op_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RWAIT,
        B_MRD,
        B_MACC,
        B_MWR,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [2:0]            ev;
        logic [23:0]           addr;
        logic [7:0]            data;
        logic                  wr_en;
        logic [MODN_BITS-1:0]  mod_n;
        logic [31:0]           offset;
        logic [23:0]           rec;
        logic [23:0]           start;
        logic [23:0]           length;
        logic [23:0]           entry;
        logic [1:0]            err;
    } cmd_t;

    // {bad, value}
    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [4:0] r;
        begin
            if (ch >= 8'h30 && ch <= 8'h39)
                r = {1'b0, 4'(ch - 8'h30)};
            else if (ch >= 8'h41 && ch <= 8'h46)
                r = {1'b0, 4'(ch - 8'h37)};
            else if (ch >= 8'h61 && ch <= 8'h66)
                r = {1'b0, 4'(ch - 8'h57)};
            else
                r = 5'h10;
            return r;
        end
    endfunction

    function automatic logic in_mem(input logic [23:0] a);
        return (a >> MEM_ADDR_BITS) == 24'd0;
    endfunction

endpackage

@@ rtl/orl_front.sv @@
`timescale 1ns / 1ps
// Record parser: takes characters and read requests, issues memory commands.
module orl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [7:0]          char_in,
    input  logic [23:0]         read_address,
    input  logic                q_full,
    output logic                q_push,
    output orl_pkg::cmd_t       q_cmd
);

    logic [23:0]        load_reg, load_next;
    logic [7:0]         column_reg, column_next;
    orl_pkg::rec_kind_t kind_reg, kind_next;
    logic [23:0]        accum_reg, accum_next;
    logic [23:0]        wp_reg, wp_next;
    logic [7:0]         hbc_reg, hbc_next;
    logic [4:0]         pend_reg, pend_next;
    logic [1:0]         err_reg, err_next;
    logic [23:0]        start_reg, start_next;
    logic [23:0]        length_reg, length_next;
    logic [23:0]        entry_reg, entry_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    always_comb
    begin
        logic [4:0]  hv;
        logic [3:0]  d;
        logic [7:0]  c;
        logic [7:0]  last;
        logic [23:0] acc;
        logic [23:0] reloc;
        load_next   = cfg_valid ? cfg_data : load_reg;
        column_next = column_reg;
        kind_next   = kind_reg;
        accum_next  = accum_reg;
        wp_next     = wp_reg;
        hbc_next    = hbc_reg;
        pend_next   = pend_reg;
        err_next    = err_reg;
        start_next  = start_reg;
        length_next = length_reg;
        entry_next  = entry_reg;
        q_push      = 1'b0;
        q_cmd       = '0;
        hv          = orl_pkg::hex_val(char_in);
        d           = hv[3:0];
        c           = column_reg;
        last        = column_reg - 8'd1;
        acc         = {accum_reg[19:0], d};
        reloc       = 24'd0;
        if (in_valid && in_ready)
        begin
            if (action)
            begin
                q_push      = 1'b1;
                q_cmd.op    = orl_pkg::CMD_READ;
                q_cmd.ev    = orl_pkg::EV_READ;
                q_cmd.addr  = read_address;
            end
            else if (char_in == orl_pkg::CH_CR)
            begin
                column_next = column_reg;
            end
            else if (char_in != orl_pkg::CH_LF)
            begin
                if (column_reg != 8'd255)
                    column_next = column_reg + 8'd1;
                if (c == 8'd0)
                begin
                    accum_next = 24'd0;
                    if (char_in == orl_pkg::CH_H)
                    begin
                        kind_next   = orl_pkg::KIND_H;
                        start_next  = 24'd0;
                        length_next = 24'd0;
                    end
                    else if (char_in == orl_pkg::CH_T)
                        kind_next = orl_pkg::KIND_T;
                    else if (char_in == orl_pkg::CH_M)
                        kind_next = orl_pkg::KIND_M;
                    else if (char_in == orl_pkg::CH_E)
                        kind_next = orl_pkg::KIND_E;
                    else
                        kind_next = orl_pkg::KIND_NONE;
                end
                else
                begin
                    unique case (kind_reg)
                        orl_pkg::KIND_H:
                        begin
                            if (c >= 8'd7 && c <= 8'd18)
                            begin
                                if (hv[4] && err_next == orl_pkg::ERR_NONE)
                                    err_next = orl_pkg::ERR_HEX;
                                accum_next = acc;
                                if (c == 8'd12)
                                begin
                                    start_next = acc;
                                    accum_next = 24'd0;
                                end
                                if (c == 8'd18)
                                begin
                                    length_next = acc;
                                    accum_next  = 24'd0;
                                end
                            end
                        end
                        orl_pkg::KIND_T, orl_pkg::KIND_M:
                        begin
                            if (hv[4] && err_next == orl_pkg::ERR_NONE
                                && (c <= 8'd8 || kind_reg == orl_pkg::KIND_T))
                                err_next = orl_pkg::ERR_HEX;
                            if (c <= 8'd6)
                            begin
                                accum_next = acc;
                                if (c == 8'd6)
                                begin
                                    reloc      = load_reg + acc - start_reg;
                                    accum_next = reloc;
                                    wp_next    = reloc;
                                end
                            end
                            else if (c <= 8'd8)
                            begin
                                if (kind_reg == orl_pkg::KIND_M)
                                    hbc_next = {hbc_reg[3:0], d};
                            end
                            else if (kind_reg == orl_pkg::KIND_T)
                            begin
                                if (pend_reg[4])
                                begin
                                    if (orl_pkg::in_mem(wp_reg))
                                    begin
                                        q_push     = 1'b1;
                                        q_cmd.op   = orl_pkg::CMD_WRITE;
                                        q_cmd.addr = wp_reg;
                                        q_cmd.data = {pend_reg[3:0], d};
                                    end
                                    else if (err_next == orl_pkg::ERR_NONE)
                                        err_next = orl_pkg::ERR_RANGE;
                                    wp_next   = wp_reg + 24'd1;
                                    pend_next = 5'd0;
                                end
                                else
                                    pend_next = {1'b1, d};
                            end
                        end
                        orl_pkg::KIND_E:
                        begin
                            if (c <= 8'd6)
                            begin
                                if (hv[4] && err_next == orl_pkg::ERR_NONE)
                                    err_next = orl_pkg::ERR_HEX;
                                accum_next = acc;
                            end
                        end
                        default:
                        begin
                            accum_next = accum_reg;
                        end
                    endcase
                end
            end
            else
            begin
                // end of line
                if (column_reg != 8'd0 && kind_reg != orl_pkg::KIND_NONE)
                begin
                    acc    = accum_reg;
                    reloc  = load_reg + accum_reg - start_reg;
                    q_cmd.op = orl_pkg::CMD_EVENT;
                    unique case (kind_reg)
                        orl_pkg::KIND_H:
                        begin
                            q_cmd.ev = orl_pkg::EV_HEADER;
                            if (last >= 8'd7 && last <= 8'd11)
                                start_next = accum_reg;
                            if (last >= 8'd13 && last <= 8'd17)
                                length_next = accum_reg;
                        end
                        orl_pkg::KIND_T:
                        begin
                            q_cmd.ev = orl_pkg::EV_TEXT;
                            if (last < 8'd6)
                                acc = reloc;
                            q_cmd.rec   = acc;
                            q_cmd.wr_en = pend_reg[4];
                            q_cmd.addr  = (last < 8'd6) ? reloc : wp_reg;
                            q_cmd.data  = {4'd0, pend_reg[3:0]};
                        end
                        orl_pkg::KIND_M:
                        begin
                            q_cmd.ev = orl_pkg::EV_MOD;
                            if (last < 8'd6)
                                acc = reloc;
                            q_cmd.rec  = acc;
                            q_cmd.addr = acc;
                            if (hbc_reg > 8'(2 * orl_pkg::MAX_MOD_BYTES))
                            begin
                                if (err_next == orl_pkg::ERR_NONE)
                                    err_next = orl_pkg::ERR_MODLONG;
                            end
                            else
                                q_cmd.mod_n = orl_pkg::MODN_BITS'((hbc_reg + 8'd1) >> 1);
                            q_cmd.offset = {8'd0, load_reg} - {8'd0, start_reg};
                        end
                        default:
                        begin
                            q_cmd.ev   = orl_pkg::EV_END;
                            entry_next = accum_reg;
                        end
                    endcase
                    q_push = 1'b1;
                    q_cmd.err = err_next;
                end
                column_next = 8'd0;
                kind_next   = orl_pkg::KIND_NONE;
                accum_next  = 24'd0;
                hbc_next    = 8'd0;
                pend_next   = 5'd0;
                err_next    = orl_pkg::ERR_NONE;
            end
            q_cmd.start  = start_next;
            q_cmd.length = length_next;
            q_cmd.entry  = entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg   <= 24'd0;
            column_reg <= 8'd0;
            kind_reg   <= orl_pkg::KIND_NONE;
            accum_reg  <= 24'd0;
            wp_reg     <= 24'd0;
            hbc_reg    <= 8'd0;
            pend_reg   <= 5'd0;
            err_reg    <= orl_pkg::ERR_NONE;
            start_reg  <= 24'd0;
            length_reg <= 24'd0;
            entry_reg  <= 24'd0;
        end
        else
        begin
            load_reg   <= load_next;
            column_reg <= column_next;
            kind_reg   <= kind_next;
            accum_reg  <= accum_next;
            wp_reg     <= wp_next;
            hbc_reg    <= hbc_next;
            pend_reg   <= pend_next;
            err_reg    <= err_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            entry_reg  <= entry_next;
        end
    end

endmodule

@@ rtl/orl_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the parser and the memory engine.
module orl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  orl_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output orl_pkg::cmd_t head
);

    orl_pkg::cmd_t                 slot_reg [orl_pkg::QUEUE_DEPTH];
    logic [orl_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [orl_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [orl_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign full      = count_reg == orl_pkg::QCNT_BITS'(orl_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == orl_pkg::QPTR_BITS'(orl_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == orl_pkg::QPTR_BITS'(orl_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/orl_back.sv @@
`timescale 1ns / 1ps
// Memory engine: byte store, clearing pass, writes, reads, modification and result word.
module orl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  orl_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    event_res,
    output logic [23:0]   start_address,
    output logic [23:0]   program_length,
    output logic [23:0]   entry_address,
    output logic [23:0]   record_address,
    output logic [7:0]    read_data,
    output logic [1:0]    error_code
);

    localparam int AB = orl_pkg::MEM_ADDR_BITS;

    logic [7:0] mem [2**AB];
    logic [7:0] rdata_reg;

    orl_pkg::back_state_t         state_reg, state_next;
    orl_pkg::cmd_t                work_reg, work_next;
    logic [AB:0]                  clr_reg, clr_next;
    logic [orl_pkg::MODN_BITS-1:0] idx_reg, idx_next;
    logic [31:0]                  v_reg, v_next;
    logic [1:0]                   err_reg, err_next;
    logic                         rd_ok_reg, rd_ok_next;

    logic                         ov_reg, ov_next;
    logic [2:0]                   ev_reg, ev_next;
    logic [23:0]                  st_reg, st_next;
    logic [23:0]                  ln_reg, ln_next;
    logic [23:0]                  en_reg, en_next;
    logic [23:0]                  ra_reg, ra_next;
    logic [7:0]                   rd_reg, rd_next;
    logic [1:0]                   ec_reg, ec_next;

    logic          we, re;
    logic [AB-1:0] wa, ra;
    logic [7:0]    wd;
    logic          slot_free;
    logic [23:0]   a;

    assign slot_free      = !ov_reg || out_ready;
    assign out_valid      = ov_reg;
    assign event_res      = ev_reg;
    assign start_address  = st_reg;
    assign program_length = ln_reg;
    assign entry_address  = en_reg;
    assign record_address = ra_reg;
    assign read_data      = rd_reg;
    assign error_code     = ec_reg;

    always_comb
    begin
        state_next = state_reg;
        work_next  = work_reg;
        clr_next   = clr_reg;
        idx_next   = idx_reg;
        v_next     = v_reg;
        err_next   = err_reg;
        rd_ok_next = rd_ok_reg;
        ov_next    = ov_reg && !out_ready;
        ev_next    = ev_reg;
        st_next    = st_reg;
        ln_next    = ln_reg;
        en_next    = en_reg;
        ra_next    = ra_reg;
        rd_next    = rd_reg;
        ec_next    = ec_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        wa         = '0;
        wd         = 8'd0;
        re         = 1'b0;
        ra         = '0;
        a          = 24'd0;
        unique case (state_reg)
            orl_pkg::B_CLEAR:
            begin
                if (clr_reg[AB])
                    state_next = orl_pkg::B_IDLE;
                else
                begin
                    we       = 1'b1;
                    wa       = clr_reg[AB-1:0];
                    clr_next = clr_reg + 1'b1;
                end
            end
            orl_pkg::B_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop     = 1'b1;
                    work_next = q_head;
                    err_next  = q_head.err;
                    unique case (q_head.op)
                        orl_pkg::CMD_WRITE:
                        begin
                            we = 1'b1;
                            wa = q_head.addr[AB-1:0];
                            wd = q_head.data;
                        end
                        orl_pkg::CMD_READ:
                        begin
                            re         = 1'b1;
                            ra         = q_head.addr[AB-1:0];
                            rd_ok_next = orl_pkg::in_mem(q_head.addr);
                            state_next = orl_pkg::B_RWAIT;
                        end
                        default:
                        begin
                            if (q_head.wr_en)
                            begin
                                if (orl_pkg::in_mem(q_head.addr))
                                begin
                                    we = 1'b1;
                                    wa = q_head.addr[AB-1:0];
                                    wd = q_head.data;
                                end
                                else if (q_head.err == orl_pkg::ERR_NONE)
                                    err_next = orl_pkg::ERR_RANGE;
                            end
                            idx_next   = '0;
                            v_next     = 32'd0;
                            state_next = (q_head.mod_n != '0) ? orl_pkg::B_MRD
                                                              : orl_pkg::B_EMIT;
                        end
                    endcase
                end
            end
            orl_pkg::B_RWAIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ev_next    = orl_pkg::EV_READ;
                    st_next    = work_reg.start;
                    ln_next    = work_reg.length;
                    en_next    = work_reg.entry;
                    ra_next    = 24'd0;
                    rd_next    = rd_ok_reg ? rdata_reg : 8'd0;
                    ec_next    = rd_ok_reg ? orl_pkg::ERR_NONE : orl_pkg::ERR_RANGE;
                    state_next = orl_pkg::B_IDLE;
                end
            end
            orl_pkg::B_MRD:
            begin
                a          = work_reg.addr + 24'(idx_reg);
                re         = 1'b1;
                ra         = a[AB-1:0];
                rd_ok_next = orl_pkg::in_mem(a);
                if (!orl_pkg::in_mem(a) && err_reg == orl_pkg::ERR_NONE)
                    err_next = orl_pkg::ERR_RANGE;
                state_next = orl_pkg::B_MACC;
            end
            orl_pkg::B_MACC:
            begin
                v_next   = {v_reg[23:0], rd_ok_reg ? rdata_reg : 8'd0};
                idx_next = idx_reg + 1'b1;
                if (idx_next == work_reg.mod_n)
                begin
                    v_next     = {v_reg[23:0], rd_ok_reg ? rdata_reg : 8'd0}
                                 + work_reg.offset;
                    state_next = orl_pkg::B_MWR;
                end
                else
                    state_next = orl_pkg::B_MRD;
            end
            orl_pkg::B_MWR:
            begin
                a = work_reg.addr + 24'(idx_reg) - 24'd1;
                if (orl_pkg::in_mem(a))
                begin
                    we = 1'b1;
                    wa = a[AB-1:0];
                    wd = v_reg[7:0];
                end
                else if (err_reg == orl_pkg::ERR_NONE)
                    err_next = orl_pkg::ERR_RANGE;
                v_next   = {8'd0, v_reg[31:8]};
                idx_next = idx_reg - 1'b1;
                if (idx_reg == orl_pkg::MODN_BITS'(1))
                    state_next = orl_pkg::B_EMIT;
            end
            default:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ev_next    = work_reg.ev;
                    st_next    = work_reg.start;
                    ln_next    = work_reg.length;
                    en_next    = work_reg.entry;
                    ra_next    = work_reg.rec;
                    rd_next    = 8'd0;
                    ec_next    = err_reg;
                    state_next = orl_pkg::B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rdata_reg <= mem[ra];
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        v_reg    <= v_next;
        ev_reg   <= ev_next;
        st_reg   <= st_next;
        ln_reg   <= ln_next;
        en_reg   <= en_next;
        ra_reg   <= ra_next;
        rd_reg   <= rd_next;
        ec_reg   <= ec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= orl_pkg::B_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
            err_reg   <= orl_pkg::ERR_NONE;
            rd_ok_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
            rd_ok_reg <= rd_ok_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

@@ rtl/object_record_relocating_loader_unit.sv @@
`timescale 1ns / 1ps
// Relocating object loader top level: parser, command queue and memory engine.
// Takes one object-program character or read request per cycle while the four-word
// command queue has room. The memory engine writes a text byte directly, answers a read
// from the registered store output, and for a modification record of n field bytes reads
// each byte in turn, adds the offset, then writes the bytes back one byte a cycle.
// After reset the store is swept to zero, during which characters that need no memory
// work are still taken but at most four commands are queued and no result is given;
// load_address may be written at any time while the block is idle.
module object_record_relocating_loader_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  char_in,
    input  logic [23:0] read_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [23:0] start_address,
    output logic [23:0] program_length,
    output logic [23:0] entry_address,
    output logic [23:0] record_address,
    output logic [7:0]  read_data,
    output logic [1:0]  error_code
);

    logic          q_full, q_push, q_pop, q_not_empty;
    orl_pkg::cmd_t q_cmd, q_head;

    orl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .char_in      (char_in),
        .read_address (read_address),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    orl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    orl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .start_address  (start_address),
        .program_length (program_length),
        .entry_address  (entry_address),
        .record_address (record_address),
        .read_data      (read_data),
        .error_code     (error_code)
    );

endmodule
